>>> design/bnlm_pkg.sv
`default_nettype none
package bnlm_pkg;

  localparam int REQ_W     = 2;
  localparam int NODE_W    = 6;
  localparam int LIM_W     = 17;
  localparam int IDENT_W   = 29;
  localparam int BYTE_W    = 8;
  localparam int DT_W      = 16;
  localparam int EV_W      = 4;
  localparam int RR_W      = 2;
  localparam int KIND_W    = 2;

  localparam int IN_W      = NODE_W + LIM_W + IDENT_W + 3 * BYTE_W + DT_W;
  localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] RESTART_MARK = 8'hFF;
  localparam logic [BYTE_W-1:0] KB_CODE_A    = 8'd3;
  localparam logic [BYTE_W-1:0] KB_CODE_B    = 8'd23;
  localparam logic [BYTE_W-1:0] KB_CODE_C    = 8'd28;
  localparam logic [BYTE_W-1:0] REASON_MAX   = 8'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_REGISTER = 2'd0,
    REQ_MESSAGE  = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_QUERY    = 2'd3
  } req_e;

  typedef enum logic [EV_W-1:0] {
    EV_REGISTERED = 4'd0,
    EV_BAD_NUMBER = 4'd1,
    EV_IN_USE     = 4'd2,
    EV_MSG_KNOWN  = 4'd3,
    EV_MSG_REPORT = 4'd4,
    EV_MSG_IGNORE = 4'd5,
    EV_LOST       = 4'd6,
    EV_TICK_DONE  = 4'd7,
    EV_STATUS     = 4'd8
  } ev_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_A       = 2'd1,
    KIND_B       = 2'd2,
    KIND_C       = 2'd3
  } kind_e;

  localparam logic [RR_W-1:0] RR_NONE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_T_ORD,
    ST_T_NODE,
    ST_T_UPD,
    ST_T_DONE
  } state_e;

  typedef struct packed {
    logic [DT_W-1:0]          elapsed_seconds;
    logic [BYTE_W-1:0]        reason_byte;
    logic [BYTE_W-1:0]        kind_byte;
    logic [BYTE_W-1:0]        first_byte;
    logic [IDENT_W-1:0]       message_ident;
    logic signed [LIM_W-1:0]  timeout_limit;
    logic [NODE_W-1:0]        node_number;
  } in_t;

  typedef struct packed {
    logic              is_active;
    logic              is_registered;
    logic [KIND_W-1:0] device_kind;
    logic              extra_ident_bits;
    logic [RR_W-1:0]   restart_reason;
    logic              went_online;
    logic [NODE_W-1:0] local_index;
    logic [NODE_W-1:0] node_id;
  } res_t;

  localparam int RES_W      = $bits(res_t);
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

endpackage
`default_nettype wire

>>> design/bus_node_liveness_monitor_unit.sv
// Register, message and query: one result, loaded into the output register
//   from ST_RESP once that register is free; the next item is accepted after that.
// Tick: for each registered node, order lookup, node lookup and the add/compare
//   unit in turn, then a done result; lost and done results wait on the output side.
// Reset (rst_ni low, async): clears node flags, node count, ignore bit and
//   output valid; RAM contents are not cleared and are used only once written.
`default_nettype none
module bus_node_liveness_monitor_unit #(
  parameter int NODE_SLOTS = 64,
  parameter int IDLE_BITS  = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_wdata_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // node_number, timeout_limit, message_ident, first_byte, kind_byte,
  // reason_byte, elapsed_seconds, zero pad
  input  wire logic [bnlm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type
  input  wire logic [bnlm_pkg::REQ_W-1:0]          s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // node_id, local_index, went_online, restart_reason, extra_ident_bits,
  // device_kind, is_registered, is_active, zero pad
  output logic      [bnlm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // event_res
  output logic      [bnlm_pkg::EV_W-1:0]           m_axis_tuser,
  output logic                                     m_axis_tlast
);
  import bnlm_pkg::*;

  localparam int SlotW = $clog2(NODE_SLOTS);
  localparam int NodeW = LIM_W + SlotW;

  state_e                 state_q, state_d;
  req_e                   req_q, req_d;
  in_t                    item_q, item_d, in_w;
  logic [SlotW-1:0]       i_q, i_d;
  logic [SlotW-1:0]       count_q, count_d;
  logic [SlotW-1:0]       tnode_q, tnode_d;
  logic                   ign_q;
  logic [NODE_SLOTS-1:0]  reg_flags_q, reg_flags_d;
  logic [NODE_SLOTS-1:0]  online_q, online_d;

  logic                   out_valid_q, out_valid_d;
  res_t                   out_res_q, out_res_d;
  ev_e                    out_ev_q, out_ev_d;
  logic                   out_last_q, out_last_d;
  logic                   out_ok;

  logic                   node_we, node_re, idle_we, idle_re, ord_we, ord_re;
  logic [SlotW-1:0]       node_waddr, node_raddr, idle_waddr, idle_raddr;
  logic [SlotW-1:0]       ord_waddr, ord_raddr;
  logic [NodeW-1:0]       node_wdata, node_rdata;
  logic [IDLE_BITS-1:0]   idle_wdata, idle_rdata;
  logic [SlotW-1:0]       ord_wdata, ord_rdata;

  logic [IDLE_BITS-1:0]   alu_sum;
  logic                   alu_over;

  logic [NODE_W-1:0]      sel;
  logic [SlotW-1:0]       sel_idx;
  logic                   in_tab, node_ok, reg_hit, ext;
  logic [RR_W-1:0]        rr;
  kind_e                  kind;
  logic [SlotW-1:0]       node_idx;
  logic                   lost;

  assign in_w = in_t'(s_axis_tdata[IN_W-1:0]);

  bnlm_ram #(.WIDTH(NodeW), .DEPTH(NODE_SLOTS)) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (node_we),
    .waddr_i(node_waddr),
    .wdata_i(node_wdata),
    .re_i   (node_re),
    .raddr_i(node_raddr),
    .rdata_o(node_rdata)
  );

  bnlm_ram #(.WIDTH(IDLE_BITS), .DEPTH(NODE_SLOTS)) u_idle_ram (
    .clk_i  (clk_i),
    .we_i   (idle_we),
    .waddr_i(idle_waddr),
    .wdata_i(idle_wdata),
    .re_i   (idle_re),
    .raddr_i(idle_raddr),
    .rdata_o(idle_rdata)
  );

  bnlm_ram #(.WIDTH(SlotW), .DEPTH(NODE_SLOTS)) u_order_ram (
    .clk_i  (clk_i),
    .we_i   (ord_we),
    .waddr_i(ord_waddr),
    .wdata_i(ord_wdata),
    .re_i   (ord_re),
    .raddr_i(ord_raddr),
    .rdata_o(ord_rdata)
  );

  bnlm_alu #(.IDLE_BITS(IDLE_BITS)) u_alu (
    .idle_i (idle_rdata),
    .dt_i   (item_q.elapsed_seconds),
    .limit_i(node_rdata[NodeW-1:SlotW]),
    .sum_o  (alu_sum),
    .over_o (alu_over)
  );

  // decode of the held item
  always_comb begin
    sel      = (req_q == REQ_MESSAGE) ? item_q.message_ident[7:2] : item_q.node_number;
    sel_idx  = sel[SlotW-1:0];
    in_tab   = ({1'b0, sel} < (NODE_W + 1)'(NODE_SLOTS));
    node_ok  = in_tab && (sel != '0);
    reg_hit  = in_tab && reg_flags_q[sel_idx];
    node_idx = node_rdata[SlotW-1:0];
    ext      = |item_q.message_ident[IDENT_W-1:11];
    rr       = (item_q.first_byte == RESTART_MARK && item_q.reason_byte <= REASON_MAX) ?
               item_q.reason_byte[RR_W-1:0] : RR_NONE;
    case (item_q.kind_byte)
      KB_CODE_A: kind = KIND_A;
      KB_CODE_B: kind = KIND_B;
      KB_CODE_C: kind = KIND_C;
      default:   kind = KIND_UNKNOWN;
    endcase
    lost = alu_over && online_q[tnode_q] && reg_flags_q[tnode_q];
  end

  assign out_ok = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    item_d      = item_q;
    i_d         = i_q;
    count_d     = count_q;
    tnode_d     = tnode_q;
    reg_flags_d = reg_flags_q;
    online_d    = online_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_res_d   = out_res_q;
    out_ev_d    = out_ev_q;
    out_last_d  = out_last_q;
    s_axis_tready = 1'b0;
    node_we = 1'b0;  node_re = 1'b0;
    idle_we = 1'b0;  idle_re = 1'b0;
    ord_we  = 1'b0;  ord_re  = 1'b0;
    node_waddr = sel_idx;
    node_wdata = {item_q.timeout_limit, count_q};
    node_raddr = (in_w.node_number != '0 && s_axis_tuser == REQ_MESSAGE) ?
                 in_w.message_ident[SlotW+1:2] : in_w.node_number[SlotW-1:0];
    idle_waddr = sel_idx;
    idle_wdata = '0;
    idle_raddr = ord_rdata;
    ord_waddr  = count_q;
    ord_wdata  = sel_idx;
    ord_raddr  = i_q;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          req_d   = req_e'(s_axis_tuser);
          item_d  = in_w;
          node_re = 1'b1;
          i_d     = '0;
          state_d = (req_e'(s_axis_tuser) == REQ_TICK) ? ST_T_ORD : ST_RESP;
          if (s_axis_tuser == REQ_MESSAGE) begin
            node_raddr = in_w.message_ident[SlotW+1:2];
          end
        end
      end
      ST_RESP: begin
        if (out_ok) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_res_d   = '0;
          out_res_d.node_id        = sel;
          out_res_d.restart_reason = RR_NONE;
          out_ev_d    = EV_STATUS;
          state_d     = ST_IDLE;
          unique case (req_q)
            REQ_REGISTER: begin
              if (!node_ok) begin
                out_ev_d = EV_BAD_NUMBER;
              end else if (reg_hit) begin
                out_ev_d = EV_IN_USE;
              end else begin
                out_ev_d = EV_REGISTERED;
                out_res_d.local_index = NODE_W'(count_q);
                node_we  = 1'b1;
                idle_we  = 1'b1;
                ord_we   = 1'b1;
                count_d  = count_q + 1'b1;
                reg_flags_d[sel_idx] = 1'b1;
              end
            end
            REQ_MESSAGE: begin
              out_res_d.extra_ident_bits = ext;
              if (reg_hit) begin
                out_ev_d = EV_MSG_KNOWN;
                out_res_d.local_index    = NODE_W'(node_idx);
                out_res_d.went_online    = !online_q[sel_idx];
                out_res_d.restart_reason = rr;
                idle_we  = 1'b1;
                online_d[sel_idx] = 1'b1;
              end else if (ign_q) begin
                out_ev_d = EV_MSG_IGNORE;
              end else begin
                out_ev_d = EV_MSG_REPORT;
                out_res_d.restart_reason = rr;
                out_res_d.device_kind    = kind;
              end
            end
            REQ_QUERY: begin
              if (node_ok) begin
                out_res_d.is_registered = reg_hit;
                out_res_d.is_active     = online_q[sel_idx];
                out_res_d.local_index   = reg_hit ? NODE_W'(node_idx) : '0;
              end
            end
            default: begin
              state_d = ST_T_ORD;
            end
          endcase
        end
      end
      ST_T_ORD: begin
        if (i_q == count_q) begin
          state_d = ST_T_DONE;
        end else begin
          ord_re  = 1'b1;
          state_d = ST_T_NODE;
        end
      end
      ST_T_NODE: begin
        idle_re    = 1'b1;
        node_re    = 1'b1;
        node_raddr = ord_rdata;
        tnode_d    = ord_rdata;
        state_d    = ST_T_UPD;
      end
      ST_T_UPD: begin
        if (!lost || out_ok) begin
          idle_we    = 1'b1;
          idle_waddr = tnode_q;
          idle_wdata = alu_sum;
          i_d        = i_q + 1'b1;
          state_d    = ST_T_ORD;
          if (lost) begin
            online_d[tnode_q] = 1'b0;
            out_valid_d = 1'b1;
            out_last_d  = 1'b0;
            out_ev_d    = EV_LOST;
            out_res_d   = '0;
            out_res_d.node_id        = NODE_W'(tnode_q);
            out_res_d.local_index    = NODE_W'(i_q);
            out_res_d.restart_reason = RR_NONE;
          end
        end
      end
      ST_T_DONE: begin
        if (out_ok) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_ev_d    = EV_TICK_DONE;
          out_res_d   = '0;
          out_res_d.restart_reason = RR_NONE;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ign_q       <= 1'b0;
      reg_flags_q <= '0;
      online_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      reg_flags_q <= reg_flags_d;
      online_q    <= online_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ign_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    item_q     <= item_d;
    i_q        <= i_d;
    tnode_q    <= tnode_d;
    out_res_q  <= out_res_d;
    out_ev_q   <= out_ev_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_res_q);
  assign m_axis_tuser  = out_ev_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

>>> design/bnlm_ram.sv
`default_nettype none
module bnlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> design/bnlm_alu.sv
`default_nettype none
module bnlm_alu #(
  parameter int IDLE_BITS = 32
) (
  input  wire logic        [IDLE_BITS-1:0]      idle_i,
  input  wire logic        [bnlm_pkg::DT_W-1:0] dt_i,
  input  wire logic signed [bnlm_pkg::LIM_W-1:0] limit_i,
  output logic             [IDLE_BITS-1:0]      sum_o,
  output logic                                  over_o
);
  import bnlm_pkg::*;

  logic [IDLE_BITS:0] sum_ext;

  // saturating idle update and timeout compare; negative limit never expires
  always_comb begin
    sum_ext = {1'b0, idle_i} + (IDLE_BITS + 1)'(dt_i);
    sum_o   = sum_ext[IDLE_BITS] ? {IDLE_BITS{1'b1}} : sum_ext[IDLE_BITS-1:0];
    over_o  = !limit_i[LIM_W-1] && (sum_o > IDLE_BITS'(limit_i[LIM_W-2:0]));
  end

endmodule
`default_nettype wire

>>> design/bnlm_checker.sv
`default_nettype none
module bnlm_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [bnlm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input wire logic [bnlm_pkg::EV_W-1:0]           m_axis_tuser,
  input wire logic                                m_axis_tlast
);
  import bnlm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("new input accepted while an item is in progress");

  a_only_lost_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == EV_LOST)
    else $error("non-final result that is not a lost event");

  a_tick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == EV_TICK_DONE |-> m_axis_tlast
      && m_axis_tdata[NODE_W-1:0] == '0)
    else $error("tick done result malformed");

endmodule

bind bus_node_liveness_monitor_unit bnlm_checker u_bnlm_checker (.*);
`default_nettype wire
